[rtl/core/rpwc_pkg.sv]
`default_nettype none

package rpwc_pkg;

    localparam int TIME_WIDTH_DEFAULT = 16;
    localparam int LIMIT_W = 16;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] SMS_MAX_RESET = 16'd150;
    localparam logic [LIMIT_W-1:0] CALL_MAX_RESET = 16'd999;

    localparam logic [CFG_IDX_W-1:0] REG_SMS_MAX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CALL_MAX = 1'b1;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_MSG = 2'd1;
    localparam logic [1:0] ST_CALL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic action;
        logic ri_level;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         ring_status;
        logic [COUNT_W-1:0] sms_count;
        logic [COUNT_W-1:0] call_count;
    } rsp_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] sms_max_ms;
        logic [LIMIT_W-1:0] call_max_ms;
    } limits_t;

endpackage

`default_nettype wire

[rtl/core/rpwc_cfg_regs.sv]
`default_nettype none

module rpwc_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [rpwc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [rpwc_pkg::CFG_DATA_W-1:0]   wr_data,
    output rpwc_pkg::limits_t                      limits
);
    import rpwc_pkg::*;

    logic [LIMIT_W-1:0] sms_max_reg;
    logic [LIMIT_W-1:0] sms_max_next;
    logic [LIMIT_W-1:0] call_max_reg;
    logic [LIMIT_W-1:0] call_max_next;

    always_comb
    begin
        sms_max_next = sms_max_reg;
        call_max_next = call_max_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SMS_MAX:  sms_max_next = wr_data[LIMIT_W-1:0];
                REG_CALL_MAX: call_max_next = wr_data[LIMIT_W-1:0];
                default:      sms_max_next = sms_max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sms_max_reg <= SMS_MAX_RESET;
            call_max_reg <= CALL_MAX_RESET;
        end
        else
        begin
            sms_max_reg <= sms_max_next;
            call_max_reg <= call_max_next;
        end
    end

    assign limits.sms_max_ms = sms_max_reg;
    assign limits.call_max_ms = call_max_reg;

endmodule

`default_nettype wire

[rtl/core/rpwc_classifier.sv]
`default_nettype none

module rpwc_classifier #(
    parameter int TIME_WIDTH = rpwc_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire rpwc_pkg::cmd_t    cmd,
    input  wire rpwc_pkg::limits_t limits,
    output rpwc_pkg::rsp_t     rsp
);
    import rpwc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
    localparam logic [TIME_WIDTH-1:0] TICKS_MAX = {TIME_WIDTH{1'b1}};

    logic                  last_level_reg;
    logic                  last_level_next;
    logic                  low_seen_reg;
    logic                  low_seen_next;
    logic [TIME_WIDTH-1:0] low_ticks_reg;
    logic [TIME_WIDTH-1:0] low_ticks_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [COUNT_W-1:0]    msg_cnt_reg;
    logic [COUNT_W-1:0]    msg_cnt_next;
    logic [COUNT_W-1:0]    call_cnt_reg;
    logic [COUNT_W-1:0]    call_cnt_next;
    logic [TIME_WIDTH-1:0] ticks_inc;
    logic [CMP_W-1:0]      width_ext;
    logic                  is_msg;
    logic                  is_call;
    logic [1:0]            shown;

    // The pulse width is always at least one, so only the upper limits matter.
    assign ticks_inc = (low_ticks_reg == TICKS_MAX) ? TICKS_MAX : low_ticks_reg + 1'b1;
    assign width_ext = CMP_W'(ticks_inc);
    assign is_msg = width_ext <= CMP_W'(limits.sms_max_ms);
    assign is_call = width_ext <= CMP_W'(limits.call_max_ms);

    always_comb
    begin
        last_level_next = last_level_reg;
        low_seen_next = low_seen_reg;
        low_ticks_next = low_ticks_reg;
        status_next = status_reg;
        msg_cnt_next = msg_cnt_reg;
        call_cnt_next = call_cnt_reg;
        shown = status_reg;
        if (cmd.action == ACT_READ)
        begin
            status_next = ST_NONE;
        end
        else
        begin
            if (!cmd.ri_level)
            begin
                if (last_level_reg)
                begin
                    low_ticks_next = '0;
                    low_seen_next = 1'b1;
                end
                else
                begin
                    low_ticks_next = ticks_inc;
                end
            end
            else if (!last_level_reg)
            begin
                if (low_seen_reg)
                begin
                    if (is_msg)
                    begin
                        msg_cnt_next = msg_cnt_reg + 1'b1;
                        status_next = ST_MSG;
                    end
                    else if (is_call)
                    begin
                        call_cnt_next = call_cnt_reg + 1'b1;
                        status_next = ST_CALL;
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                    end
                end
                else
                begin
                    status_next = ST_UNKNOWN;
                end
                low_seen_next = 1'b0;
            end
            last_level_next = cmd.ri_level;
            shown = status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            low_seen_reg <= 1'b0;
            low_ticks_reg <= '0;
            status_reg <= ST_NONE;
            msg_cnt_reg <= '0;
            call_cnt_reg <= '0;
        end
        else if (en)
        begin
            last_level_reg <= last_level_next;
            low_seen_reg <= low_seen_next;
            low_ticks_reg <= low_ticks_next;
            status_reg <= status_next;
            msg_cnt_reg <= msg_cnt_next;
            call_cnt_reg <= call_cnt_next;
        end
    end

    assign rsp.ring_status = shown;
    assign rsp.sms_count = msg_cnt_next;
    assign rsp.call_count = call_cnt_next;

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && cmd.action == ACT_READ |=> status_reg == ST_NONE)
        else $error("status not cleared after a read");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(msg_cnt_reg) && $stable(call_cnt_reg) && $stable(status_reg))
        else $error("state changed without an item");

    a_low_seen_low: assert property (@(posedge clk) disable iff (!rst_n)
        low_seen_reg |-> !last_level_reg)
        else $error("pulse open while line is high");

endmodule

`default_nettype wire

[rtl/core/ring_pulse_width_classifier.sv]
// Ring-indicator pulse width classifier.
// The cmd channel carries one item per millisecond tick (action tick, with the
// sampled pin level) or a read-and-clear of the sticky ring status. Every cmd
// item yields exactly one rsp item with the ring status and both pulse counters.
// An item is taken at a rising edge with valid high and stall low.
// An item lands in the input register and is then classified into the result
// register. Throughput is one item per cycle unless the receiver stalls; the
// classifier state is a single register set updated once per item.
// When the receiver stalls, the result register holds its item and the input
// register keeps the next one, so cmd_stall rises only once both are full.
// The wr_* port writes the message and call limits; write only while idle.
// Reset clears the pipeline, sets the line to idle high, clears status and
// counters, and loads the limits with 150 and 999 ticks.
`default_nettype none

module ring_pulse_width_classifier #(
    parameter int TIME_WIDTH = rpwc_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [rpwc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [rpwc_pkg::CFG_DATA_W-1:0]  wr_data,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_stall,
    input  wire rpwc_pkg::cmd_t                   cmd,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output rpwc_pkg::rsp_t                        rsp
);
    import rpwc_pkg::*;

    limits_t limits;
    cmd_t    cmd_reg;
    logic    cmd_valid_reg;
    logic    cmd_valid_next;
    rsp_t    rsp_reg;
    rsp_t    rsp_new;
    logic    rsp_valid_reg;
    logic    rsp_valid_next;
    logic    out_ready;
    logic    advance;
    logic    accept;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign advance = cmd_valid_reg && out_ready;
    assign cmd_stall = cmd_valid_reg && !out_ready;
    assign accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    rpwc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .limits   (limits)
    );

    rpwc_classifier #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classifier (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .cmd    (cmd_reg),
        .limits (limits),
        .rsp    (rsp_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

`default_nettype wire
